// ----- rtl/rational_accumulator_alu_assert.svh -----
// Assertion macros used by the rational accumulator ALU top level.
`ifndef RATIONAL_ACCUMULATOR_ALU_ASSERT_SVH
`define RATIONAL_ACCUMULATOR_ALU_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rca_pkg.sv -----
// Package: item types, operation codes and the microcode table of the rational accumulator ALU.
package rca_pkg;

    localparam int RCA_WORD_BITS = 32;

    // Operation codes of the func field.
    localparam logic [2:0] FN_ADD  = 3'd0;
    localparam logic [2:0] FN_SUB  = 3'd1;
    localparam logic [2:0] FN_MUL  = 3'd2;
    localparam logic [2:0] FN_DIV  = 3'd3;
    localparam logic [2:0] FN_LOAD = 3'd4;

    typedef struct packed {
        logic [2:0]          func;
        logic signed [31:0]  operand_num;
        logic signed [31:0]  operand_den;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0]  result_num;
        logic signed [31:0]  result_den;
        logic                overflow;
    } t_out_item;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_GCD_FIN,
        OP_DIV_START_NUM,
        OP_DIV_START_DEN,
        OP_DIV_STEP,
        OP_DIV_PUT_NUM,
        OP_DIV_PUT_DEN,
        OP_MUL_START,
        OP_MUL_STEP,
        OP_MUL_PUT,
        OP_ADDSUB,
        OP_MOVE_T0_XN,
        OP_WRITEBACK,
        OP_EMIT
    } t_uop;

    // Jump conditions.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_ZERO_PART,
        C_GCD_BUSY,
        C_CNT_NZ,
        C_PASS2,
        C_FUNC_BAD,
        C_FUNC_LOAD,
        C_FUNC_MUL,
        C_FUNC_DIV
    } t_cond;

    // Multiplier operand pairs (an/ad accumulator, on/od working fraction).
    typedef enum logic [2:0] {
        M_AN_OD,
        M_ON_AD,
        M_AD_OD,
        M_AN_ON,
        M_AD_ON
    } t_msel;

    // Product destinations.
    typedef enum logic [1:0] {
        D_T0,
        D_T1,
        D_XN,
        D_XD
    } t_mdst;

    // Microprogram steps, in table order.
    typedef enum logic [5:0] {
        UA_IDLE,
        UA_ENTRY,
        UA_RED,
        UA_GCD_LOOP,
        UA_GCD_FIN,
        UA_DN_START,
        UA_DN_LOOP,
        UA_DN_PUT,
        UA_DD_START,
        UA_DD_LOOP,
        UA_DD_PUT,
        UA_RED_END,
        UA_DISP_LOAD,
        UA_DISP_MUL,
        UA_DISP_DIV,
        UA_AS_M0,
        UA_AS_L0,
        UA_AS_P0,
        UA_AS_M1,
        UA_AS_L1,
        UA_AS_P1,
        UA_AS_M2,
        UA_AS_L2,
        UA_AS_P2,
        UA_AS_SUM,
        UA_MU_M0,
        UA_MU_L0,
        UA_MU_P0,
        UA_MU_M1,
        UA_MU_L1,
        UA_MU_P1,
        UA_DV_M0,
        UA_DV_L0,
        UA_DV_P0,
        UA_DV_M1,
        UA_DV_L1,
        UA_DV_P1,
        UA_DV_MOVE,
        UA_WB,
        UA_EMIT
    } t_uaddr;

    typedef struct packed {
        t_uop    op;
        t_cond   cond;
        t_uaddr  target;
        t_msel   msel;
        t_mdst   mdst;
        logic    pass_set;
    } t_uword;

    // Datapath flags seen by the sequencer.
    typedef struct packed {
        logic zero_part;
        logic gcd_busy;
        logic cnt_nz;
        logic pass2;
        logic func_bad;
        logic func_load;
        logic func_mul;
        logic func_div;
    } t_status;

    function automatic t_uword f_uw(input t_uop op, input t_cond c, input t_uaddr tgt,
                                    input t_msel ms, input t_mdst md, input logic ps);
        t_uword w;
        w.op       = op;
        w.cond     = c;
        w.target   = tgt;
        w.msel     = ms;
        w.mdst     = md;
        w.pass_set = ps;
        return w;
    endfunction

    // Microcode table. Each word runs its op, then jumps to target when cond holds.
    function automatic t_uword f_urom(input t_uaddr a);
        t_uword w;
        case (a)
            UA_IDLE:      w = f_uw(OP_NOP, C_NEVER, UA_IDLE, M_AN_OD, D_T0, 1'b0);
            UA_ENTRY:     w = f_uw(OP_NOP, C_FUNC_BAD, UA_EMIT, M_AN_OD, D_T0, 1'b0);
            // reduce the working fraction by the gcd of its magnitudes
            UA_RED:       w = f_uw(OP_GCD_INIT, C_ZERO_PART, UA_RED_END, M_AN_OD, D_T0, 1'b0);
            UA_GCD_LOOP:  w = f_uw(OP_GCD_STEP, C_GCD_BUSY, UA_GCD_LOOP, M_AN_OD, D_T0, 1'b0);
            UA_GCD_FIN:   w = f_uw(OP_GCD_FIN, C_NEVER, UA_IDLE, M_AN_OD, D_T0, 1'b0);
            UA_DN_START:  w = f_uw(OP_DIV_START_NUM, C_NEVER, UA_IDLE, M_AN_OD, D_T0, 1'b0);
            UA_DN_LOOP:   w = f_uw(OP_DIV_STEP, C_CNT_NZ, UA_DN_LOOP, M_AN_OD, D_T0, 1'b0);
            UA_DN_PUT:    w = f_uw(OP_DIV_PUT_NUM, C_NEVER, UA_IDLE, M_AN_OD, D_T0, 1'b0);
            UA_DD_START:  w = f_uw(OP_DIV_START_DEN, C_NEVER, UA_IDLE, M_AN_OD, D_T0, 1'b0);
            UA_DD_LOOP:   w = f_uw(OP_DIV_STEP, C_CNT_NZ, UA_DD_LOOP, M_AN_OD, D_T0, 1'b0);
            UA_DD_PUT:    w = f_uw(OP_DIV_PUT_DEN, C_NEVER, UA_IDLE, M_AN_OD, D_T0, 1'b0);
            UA_RED_END:   w = f_uw(OP_NOP, C_PASS2, UA_WB, M_AN_OD, D_T0, 1'b0);
            // dispatch on the operation
            UA_DISP_LOAD: w = f_uw(OP_NOP, C_FUNC_LOAD, UA_WB, M_AN_OD, D_T0, 1'b0);
            UA_DISP_MUL:  w = f_uw(OP_NOP, C_FUNC_MUL, UA_MU_M0, M_AN_OD, D_T0, 1'b0);
            UA_DISP_DIV:  w = f_uw(OP_NOP, C_FUNC_DIV, UA_DV_M0, M_AN_OD, D_T0, 1'b0);
            // add and subtract
            UA_AS_M0:     w = f_uw(OP_MUL_START, C_NEVER, UA_IDLE, M_AN_OD, D_T0, 1'b0);
            UA_AS_L0:     w = f_uw(OP_MUL_STEP, C_CNT_NZ, UA_AS_L0, M_AN_OD, D_T0, 1'b0);
            UA_AS_P0:     w = f_uw(OP_MUL_PUT, C_NEVER, UA_IDLE, M_AN_OD, D_T0, 1'b0);
            UA_AS_M1:     w = f_uw(OP_MUL_START, C_NEVER, UA_IDLE, M_ON_AD, D_T1, 1'b0);
            UA_AS_L1:     w = f_uw(OP_MUL_STEP, C_CNT_NZ, UA_AS_L1, M_ON_AD, D_T1, 1'b0);
            UA_AS_P1:     w = f_uw(OP_MUL_PUT, C_NEVER, UA_IDLE, M_ON_AD, D_T1, 1'b0);
            UA_AS_M2:     w = f_uw(OP_MUL_START, C_NEVER, UA_IDLE, M_AD_OD, D_XD, 1'b0);
            UA_AS_L2:     w = f_uw(OP_MUL_STEP, C_CNT_NZ, UA_AS_L2, M_AD_OD, D_XD, 1'b0);
            UA_AS_P2:     w = f_uw(OP_MUL_PUT, C_NEVER, UA_IDLE, M_AD_OD, D_XD, 1'b0);
            UA_AS_SUM:    w = f_uw(OP_ADDSUB, C_ALWAYS, UA_RED, M_AN_OD, D_XN, 1'b1);
            // multiply
            UA_MU_M0:     w = f_uw(OP_MUL_START, C_NEVER, UA_IDLE, M_AN_ON, D_XN, 1'b0);
            UA_MU_L0:     w = f_uw(OP_MUL_STEP, C_CNT_NZ, UA_MU_L0, M_AN_ON, D_XN, 1'b0);
            UA_MU_P0:     w = f_uw(OP_MUL_PUT, C_NEVER, UA_IDLE, M_AN_ON, D_XN, 1'b0);
            UA_MU_M1:     w = f_uw(OP_MUL_START, C_NEVER, UA_IDLE, M_AD_OD, D_XD, 1'b0);
            UA_MU_L1:     w = f_uw(OP_MUL_STEP, C_CNT_NZ, UA_MU_L1, M_AD_OD, D_XD, 1'b0);
            UA_MU_P1:     w = f_uw(OP_MUL_PUT, C_ALWAYS, UA_RED, M_AD_OD, D_XD, 1'b1);
            // divide: accumulator over operand
            UA_DV_M0:     w = f_uw(OP_MUL_START, C_NEVER, UA_IDLE, M_AN_OD, D_T0, 1'b0);
            UA_DV_L0:     w = f_uw(OP_MUL_STEP, C_CNT_NZ, UA_DV_L0, M_AN_OD, D_T0, 1'b0);
            UA_DV_P0:     w = f_uw(OP_MUL_PUT, C_NEVER, UA_IDLE, M_AN_OD, D_T0, 1'b0);
            UA_DV_M1:     w = f_uw(OP_MUL_START, C_NEVER, UA_IDLE, M_AD_ON, D_XD, 1'b0);
            UA_DV_L1:     w = f_uw(OP_MUL_STEP, C_CNT_NZ, UA_DV_L1, M_AD_ON, D_XD, 1'b0);
            UA_DV_P1:     w = f_uw(OP_MUL_PUT, C_NEVER, UA_IDLE, M_AD_ON, D_XD, 1'b0);
            UA_DV_MOVE:   w = f_uw(OP_MOVE_T0_XN, C_ALWAYS, UA_RED, M_AN_OD, D_T0, 1'b1);
            // commit and hand over
            UA_WB:        w = f_uw(OP_WRITEBACK, C_NEVER, UA_IDLE, M_AN_OD, D_T0, 1'b0);
            UA_EMIT:      w = f_uw(OP_EMIT, C_ALWAYS, UA_IDLE, M_AN_OD, D_T0, 1'b0);
            default:      w = f_uw(OP_NOP, C_ALWAYS, UA_IDLE, M_AN_OD, D_T0, 1'b0);
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/rca_useq.sv -----
// Microcode sequencer: step counter, table lookup and conditional jumps.
module rca_useq
    import rca_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_stall,
    input  t_status i_status,
    output t_uword  o_uw,
    output logic    o_idle
);

    t_uaddr r_pc;
    t_uaddr n_pc;
    t_uword w_uw;
    logic   w_take;

    assign w_uw   = f_urom(r_pc);
    assign o_uw   = w_uw;
    assign o_idle = (r_pc == UA_IDLE);

    always_comb begin
        case (w_uw.cond)
            C_NEVER:     w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_ZERO_PART: w_take = i_status.zero_part;
            C_GCD_BUSY:  w_take = i_status.gcd_busy;
            C_CNT_NZ:    w_take = i_status.cnt_nz;
            C_PASS2:     w_take = i_status.pass2;
            C_FUNC_BAD:  w_take = i_status.func_bad;
            C_FUNC_LOAD: w_take = i_status.func_load;
            C_FUNC_MUL:  w_take = i_status.func_mul;
            C_FUNC_DIV:  w_take = i_status.func_div;
            default:     w_take = 1'b0;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        if (r_pc == UA_IDLE) begin
            if (i_start) begin
                n_pc = UA_ENTRY;
            end
        end else if (!i_stall) begin
            n_pc = w_take ? w_uw.target : t_uaddr'(r_pc + 6'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UA_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

// ----- rtl/rca_dpath.sv -----
// Datapath: fraction registers, bit-serial multiplier, gcd stepper and restoring divider.
module rca_dpath
    import rca_pkg::*;
#(
    parameter int WORD_BITS = RCA_WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_uword               i_uw,
    input  logic                 i_load,
    input  logic [2:0]           i_func,
    input  logic [WORD_BITS-1:0] i_num,
    input  logic [WORD_BITS-1:0] i_den,
    output t_status              o_status,
    output logic [WORD_BITS-1:0] o_acc_num,
    output logic [WORD_BITS-1:0] o_acc_den,
    output logic                 o_ovf
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W);
    localparam logic [W-1:0]  LP_ONE      = {{(W-1){1'b0}}, 1'b1};
    localparam logic [CW-1:0] LP_CNT_ONE  = {{(CW-1){1'b0}}, 1'b1};
    localparam logic [CW-1:0] LP_CNT_LAST = CW'(W - 1);

    function automatic logic [W-1:0] f_neg(input logic [W-1:0] v);
        return (~v) + LP_ONE;
    endfunction

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        return v[W-1] ? f_neg(v) : v;
    endfunction

    logic [2:0]    r_func;
    logic [W-1:0]  r_an, r_ad, r_xn, r_xd, r_t0, r_t1;
    logic          r_ovf, r_pass;
    logic [W-1:0]  r_ga, r_gb, r_g;
    logic [CW-1:0] r_gk, r_cnt;
    logic [W-1:0]  r_ma, r_ph, r_pl;
    logic          r_msign;
    logic [W-1:0]  r_dq, r_rem;

    logic [W-1:0]  w_ma, w_mb;
    logic [W:0]    w_msum;
    logic [W:0]    w_trial;
    logic [W-1:0]  w_mul_res;
    logic          w_mul_ovf;
    logic          w_as_sub;
    logic [W-1:0]  w_as_res;
    logic          w_as_ovf;
    logic          w_ovf_set;
    logic          w_gcd_busy;
    logic [W-1:0]  w_gab, w_gba;

    always_comb begin
        case (i_uw.msel)
            M_AN_OD: begin w_ma = r_an; w_mb = r_xd; end
            M_ON_AD: begin w_ma = r_xn; w_mb = r_ad; end
            M_AD_OD: begin w_ma = r_ad; w_mb = r_xd; end
            M_AN_ON: begin w_ma = r_an; w_mb = r_xn; end
            M_AD_ON: begin w_ma = r_ad; w_mb = r_xn; end
            default: begin w_ma = r_an; w_mb = r_xd; end
        endcase
    end

    // shift-add on magnitudes, low multiplier bit first
    assign w_msum    = {1'b0, r_ph} + (r_pl[0] ? {1'b0, r_ma} : {(W+1){1'b0}});
    assign w_mul_res = r_msign ? f_neg(r_pl) : r_pl;
    assign w_mul_ovf = (r_ph != '0) || (r_pl[W-1] && (!r_msign || (r_pl[W-2:0] != '0)));

    assign w_as_sub = (r_func == FN_SUB);
    assign w_as_res = w_as_sub ? (r_t0 - r_t1) : (r_t0 + r_t1);
    assign w_as_ovf = w_as_sub
        ? ((r_t0[W-1] != r_t1[W-1]) && (w_as_res[W-1] != r_t0[W-1]))
        : ((r_t0[W-1] == r_t1[W-1]) && (w_as_res[W-1] != r_t0[W-1]));

    assign w_ovf_set = ((i_uw.op == OP_MUL_PUT) && w_mul_ovf) ||
                       ((i_uw.op == OP_ADDSUB) && w_as_ovf);

    assign w_trial    = {r_rem, r_dq[W-1]} - {1'b0, r_g};
    assign w_gcd_busy = (r_ga != '0) && (r_gb != '0);
    assign w_gab      = r_ga - r_gb;
    assign w_gba      = r_gb - r_ga;

    assign o_status.zero_part = (r_xn == '0) || (r_xd == '0);
    assign o_status.gcd_busy  = w_gcd_busy;
    assign o_status.cnt_nz    = (r_cnt != '0);
    assign o_status.pass2     = r_pass;
    assign o_status.func_bad  = !(r_func inside {FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_LOAD});
    assign o_status.func_load = (r_func == FN_LOAD);
    assign o_status.func_mul  = (r_func == FN_MUL);
    assign o_status.func_div  = (r_func == FN_DIV);

    assign o_acc_num = r_an;
    assign o_acc_den = r_ad;
    assign o_ovf     = r_ovf;

    // accumulator and per-item flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_an   <= '0;
            r_ad   <= '0;
            r_ovf  <= 1'b0;
            r_pass <= 1'b0;
        end else begin
            if (i_load) begin
                r_ovf  <= 1'b0;
                r_pass <= 1'b0;
            end else begin
                if (i_uw.pass_set) begin
                    r_pass <= 1'b1;
                end
                if (w_ovf_set) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_uw.op == OP_WRITEBACK) begin
                r_an <= r_xn;
                r_ad <= r_xd;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_func <= i_func;
            r_xn   <= i_num;
            r_xd   <= i_den;
        end else begin
            case (i_uw.op)
                OP_GCD_INIT: begin
                    r_ga <= f_mag(r_xn);
                    r_gb <= f_mag(r_xd);
                    r_gk <= '0;
                end
                OP_GCD_STEP: begin
                    if (w_gcd_busy) begin
                        case ({r_ga[0], r_gb[0]})
                            2'b00: begin
                                r_ga <= {1'b0, r_ga[W-1:1]};
                                r_gb <= {1'b0, r_gb[W-1:1]};
                                r_gk <= r_gk + LP_CNT_ONE;
                            end
                            2'b01: r_ga <= {1'b0, r_ga[W-1:1]};
                            2'b10: r_gb <= {1'b0, r_gb[W-1:1]};
                            default: begin
                                // both odd: halve the difference into the larger one
                                if (r_ga >= r_gb) begin
                                    r_ga <= {1'b0, w_gab[W-1:1]};
                                end else begin
                                    r_gb <= {1'b0, w_gba[W-1:1]};
                                end
                            end
                        endcase
                    end
                end
                OP_GCD_FIN: r_g <= (r_ga | r_gb) << r_gk;
                OP_DIV_START_NUM: begin
                    r_dq  <= f_mag(r_xn);
                    r_rem <= '0;
                    r_cnt <= LP_CNT_LAST;
                end
                OP_DIV_START_DEN: begin
                    r_dq  <= f_mag(r_xd);
                    r_rem <= '0;
                    r_cnt <= LP_CNT_LAST;
                end
                OP_DIV_STEP: begin
                    if (!w_trial[W]) begin
                        r_rem <= w_trial[W-1:0];
                        r_dq  <= {r_dq[W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[W-2:0], r_dq[W-1]};
                        r_dq  <= {r_dq[W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - LP_CNT_ONE;
                end
                OP_DIV_PUT_NUM: r_xn <= r_xn[W-1] ? f_neg(r_dq) : r_dq;
                OP_DIV_PUT_DEN: r_xd <= r_xd[W-1] ? f_neg(r_dq) : r_dq;
                OP_MUL_START: begin
                    r_ma    <= f_mag(w_ma);
                    r_pl    <= f_mag(w_mb);
                    r_ph    <= '0;
                    r_msign <= w_ma[W-1] ^ w_mb[W-1];
                    r_cnt   <= LP_CNT_LAST;
                end
                OP_MUL_STEP: begin
                    r_ph  <= w_msum[W:1];
                    r_pl  <= {w_msum[0], r_pl[W-1:1]};
                    r_cnt <= r_cnt - LP_CNT_ONE;
                end
                OP_MUL_PUT: begin
                    case (i_uw.mdst)
                        D_T0:    r_t0 <= w_mul_res;
                        D_T1:    r_t1 <= w_mul_res;
                        D_XN:    r_xn <= w_mul_res;
                        D_XD:    r_xd <= w_mul_res;
                        default: ;
                    endcase
                end
                OP_ADDSUB:     r_xn <= w_as_res;
                OP_MOVE_T0_XN: r_xn <= r_t0;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/rational_accumulator_alu.sv -----
// Top level of the rational accumulator ALU: handshakes, word sizing and the result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one item: an operation
//   (add, subtract, multiply, divide, load) and an operand fraction. Output channel
//   (o_out_valid / i_out_ready / o_out_data) returns one item per input item: the new
//   accumulated fraction, gcd-reduced unless a part is zero, and an overflow flag.
//   Items are worked one at a time by a microprogram over a small datapath.
//   Each item runs through the operand reduction (gcd steps plus two divisions), two or
//   three bit-serial products, and a second reduction; a load skips the products and
//   the second reduction, and a zero part skips the gcd reduction. Unused operation
//   codes go from the entry step straight to the hand-over step. The shift-add
//   multiplier and the restoring divider each work one bit per cycle, and the
//   sequencer takes a new item only once it is back at idle.
//   o_in_ready is high whenever the sequencer is idle, also while a result still waits
//   in the output register; a stalled receiver holds the result there, and the
//   sequencer waits at its hand-over step only if a second result is ready before it.
//   Reset clears the accumulator to 0/0, empties the output register and returns the
//   sequencer to idle.
module rational_accumulator_alu
    import rca_pkg::*;
#(
    parameter int WORD_BITS = RCA_WORD_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_uword                 w_uw;
    t_status                w_status;
    logic                   w_seq_idle;
    logic                   w_in_fire;
    logic                   w_out_busy;
    logic                   w_emit_fire;
    logic                   w_stall;
    logic [WORD_BITS-1:0]   w_acc_num;
    logic [WORD_BITS-1:0]   w_acc_den;
    logic                   w_ovf;
    logic [WORD_BITS+31:0]  w_in_num_ext;
    logic [WORD_BITS+31:0]  w_in_den_ext;
    logic [WORD_BITS+31:0]  w_out_num_ext;
    logic [WORD_BITS+31:0]  w_out_den_ext;

    logic                   r_out_valid;
    t_out_item              r_out_data;
    t_out_item              n_out_data;

    // Accept only while the sequencer sits idle.
    assign o_in_ready = w_seq_idle;
    assign w_in_fire  = i_in_valid && w_seq_idle;

    // Hold the hand-over step while the result register is still occupied.
    assign w_out_busy  = r_out_valid && !i_out_ready;
    assign w_stall     = (w_uw.op == OP_EMIT) && w_out_busy;
    assign w_emit_fire = (w_uw.op == OP_EMIT) && !w_out_busy;

    // Sign-extend, then keep the working word (wraps when the word is narrower).
    assign w_in_num_ext = {{WORD_BITS{i_in_data.operand_num[31]}}, i_in_data.operand_num};
    assign w_in_den_ext = {{WORD_BITS{i_in_data.operand_den[31]}}, i_in_data.operand_den};

    // Results go out sign-extended to 32 bits.
    assign w_out_num_ext = {{32{w_acc_num[WORD_BITS-1]}}, w_acc_num};
    assign w_out_den_ext = {{32{w_acc_den[WORD_BITS-1]}}, w_acc_den};

    always_comb begin
        n_out_data.result_num = w_out_num_ext[31:0];
        n_out_data.result_den = w_out_den_ext[31:0];
        n_out_data.overflow   = w_ovf;
    end

    rca_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_in_fire),
        .i_stall  (w_stall),
        .i_status (w_status),
        .o_uw     (w_uw),
        .o_idle   (w_seq_idle)
    );

    rca_dpath #(
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_uw      (w_uw),
        .i_load    (w_in_fire),
        .i_func    (i_in_data.func),
        .i_num     (w_in_num_ext[WORD_BITS-1:0]),
        .i_den     (w_in_den_ext[WORD_BITS-1:0]),
        .o_status  (w_status),
        .o_acc_num (w_acc_num),
        .o_acc_den (w_acc_den),
        .o_ovf     (w_ovf)
    );

    // Result register: load on hand-over, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_fire) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`include "rational_accumulator_alu_assert.svh"

    `RCA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_in_fire, !o_in_ready, "ready after accept")
    `RCA_ASSERT_NXT(a_emit_fills_out, i_clk, i_rst_n, w_emit_fire, o_out_valid, "result lost")
    `RCA_ASSERT_IMP(a_no_emit_on_accept, i_clk, i_rst_n, w_in_fire, !(w_uw.op == OP_EMIT), "emit while idle")

endmodule

// ----- tb/tb_rational_accumulator_alu.sv -----
// Rational accumulator ALU testbench: directed and random fractions checked by rules or a predictor.
`timescale 1ns / 100ps

module tb_rational_accumulator_alu;
    import rca_pkg::*;

    // Spare operation codes; the block must leave the accumulator alone on these.
    localparam logic [2:0] FN_RSV5 = 3'd5;
    localparam logic [2:0] FN_RSV6 = 3'd6;
    localparam logic [2:0] FN_RSV7 = 3'd7;

    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;

    localparam int RANDOM_ITEMS = 500;
    // Receiver hold-off long enough that one result sits in the output register,
    // a second one waits at the hand-over step and the input side stalls.
    localparam int HOLDOFF_CYCLES = 1000;
    // Slowest item plus the hold-off and the longest sender gap, taken several times over.
    localparam int QUIET_LIMIT = 5000;
    // Tail after the last result: longer than any item, so a stray result shows up.
    localparam int TAIL_CYCLES = 400;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data  = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    rational_accumulator_alu dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor's copy of the accumulated fraction.
    logic signed [31:0] track_num = '0;
    logic signed [31:0] track_den = '0;

    // Fractions the block still owes, oldest first.
    t_out_item awaited_fractions[$];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  quiet_cycles   = 0;
    int  burst_left     = 0;
    bit  holdoff_done   = 1'b0;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_plan_row;

    t_plan_row directed_rows[$];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Wrap a wide value to 32 bits; bit 32 flags that it did not fit.
    function automatic logic [32:0] fit32(input longint v);
        return {v != {{32{v[31]}}, v[31:0]}, v[31:0]};
    endfunction

    // Divide both magnitudes by their gcd and put each sign back.
    // Leave the pair untouched when either part is zero.
    function automatic logic [63:0] reduce_frac(input logic signed [31:0] n,
                                                input logic signed [31:0] d);
        longint unsigned mag_n, mag_d, a, b, t;
        logic [31:0]     qn, qd;
        mag_n = (n < 0) ? -longint'(n) : longint'(n);
        mag_d = (d < 0) ? -longint'(d) : longint'(d);
        if (mag_n == 0 || mag_d == 0)
            return {n, d};
        a = mag_n;
        b = mag_d;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        t  = mag_n / a;
        qn = t[31:0];
        t  = mag_d / a;
        qd = t[31:0];
        if (n < 0)
            qn = -qn;
        if (d < 0)
            qd = -qd;
        return {qn, qd};
    endfunction

    // Advance the tracked accumulator by one item and return the fraction it shows.
    function automatic t_out_item rational_step(input t_in_item it);
        logic [63:0]        frac;
        logic signed [31:0] op_num, op_den, new_num, new_den;
        logic [32:0]        cross_a, cross_b, den_prod, mix;
        logic               wrapped;
        logic               known;
        t_out_item          r;
        frac    = reduce_frac(it.operand_num, it.operand_den);
        op_num  = frac[63:32];
        op_den  = frac[31:0];
        new_num = track_num;
        new_den = track_den;
        wrapped = 1'b0;
        known   = 1'b1;
        case (it.func)
            FN_ADD, FN_SUB: begin
                cross_a  = fit32(longint'(track_num) * longint'(op_den));
                cross_b  = fit32(longint'(op_num) * longint'(track_den));
                den_prod = fit32(longint'(track_den) * longint'(op_den));
                if (it.func == FN_ADD)
                    mix = fit32(longint'($signed(cross_a[31:0]))
                                + longint'($signed(cross_b[31:0])));
                else
                    mix = fit32(longint'($signed(cross_a[31:0]))
                                - longint'($signed(cross_b[31:0])));
                new_num = mix[31:0];
                new_den = den_prod[31:0];
                wrapped = cross_a[32] | cross_b[32] | den_prod[32] | mix[32];
            end
            FN_MUL: begin
                cross_a  = fit32(longint'(track_num) * longint'(op_num));
                den_prod = fit32(longint'(track_den) * longint'(op_den));
                new_num  = cross_a[31:0];
                new_den  = den_prod[31:0];
                wrapped  = cross_a[32] | den_prod[32];
            end
            FN_DIV: begin
                // accumulator over operand
                cross_a  = fit32(longint'(track_num) * longint'(op_den));
                den_prod = fit32(longint'(track_den) * longint'(op_num));
                new_num  = cross_a[31:0];
                new_den  = den_prod[31:0];
                wrapped  = cross_a[32] | den_prod[32];
            end
            FN_LOAD: begin
                new_num = op_num;
                new_den = op_den;
            end
            default: known = 1'b0;
        endcase
        if (known) begin
            frac      = reduce_frac(new_num, new_den);
            track_num = frac[63:32];
            track_den = frac[31:0];
        end
        r.result_num = track_num;
        r.result_den = track_den;
        r.overflow   = wrapped;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic plan(input logic [2:0] f, input logic signed [31:0] n, d,
                        input bit typed, input logic signed [31:0] wn, wd, input logic wo);
        t_plan_row row;
        row.item.func        = f;
        row.item.operand_num = n;
        row.item.operand_den = d;
        row.typed            = typed;
        row.want.result_num  = wn;
        row.want.result_den  = wd;
        row.want.overflow    = wo;
        directed_rows.push_back(row);
    endtask

    // Mostly short gaps, a few long ones, and now and then a burst with none at all.
    function automatic int pick_gap();
        int unsigned r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 6) begin
            burst_left = $urandom_range(15, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Small values most of the time so that results stay exact; full words,
    // extremes and powers of two for the wrap and reduction corners.
    function automatic logic signed [31:0] pick_part();
        int unsigned        sel;
        logic signed [31:0] p;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $signed($urandom_range(0, 40)) - 20;
        if (sel == 6)
            return $signed($urandom_range(0, 10000)) - 5000;
        if (sel == 7)
            return $urandom;
        if (sel == 8) begin
            case ($urandom_range(0, 4))
                0:       return S32_MIN;
                1:       return S32_MAX;
                2:       return 32'sd0;
                3:       return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        p = 32'sd1 <<< $urandom_range(0, 31);
        return ($urandom_range(0, 1) != 0) ? -p : p;
    endfunction

    // Reload more often once the accumulator has grown large or lost its denominator.
    function automatic logic [2:0] pick_func();
        int unsigned r;
        r = $urandom_range(0, 99);
        if ((track_den == 0 || track_num > 65536 || track_num < -65536) && r < 50)
            return FN_LOAD;
        if (r < 12)
            return FN_LOAD;
        if (r < 17)
            return FN_RSV5 + 3'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0:       return FN_ADD;
            1:       return FN_SUB;
            2:       return FN_MUL;
            default: return FN_DIV;
        endcase
    endfunction

    // Hold valid and payload until the item is taken, record what it must produce,
    // then drop valid only if a gap follows.
    task automatic offer_item(input t_in_item it, input bit typed, input t_out_item want,
                              input int gap);
        t_out_item predicted;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predicted = rational_step(it);
        awaited_fractions.push_back(typed ? want : predicted);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every owed fraction has come back.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_fractions.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sender: reset, directed table, random items, end of run
    // ------------------------------------------------------------------
    initial begin
        t_in_item item;

        // Directed table. Rows with a typed result read straight off the rules;
        // the rest go through the predictor. Accumulator starts at 0/0.
        plan(FN_RSV5, 7, 3, 1, 0, 0, 0);                   // spare code right after reset
        plan(FN_LOAD, 6, 4, 1, 3, 2, 0);                   // load reduces the operand
        plan(FN_LOAD, 0, 5, 1, 0, 5, 0);                   // zero numerator: no reduction
        plan(FN_LOAD, S32_MIN, S32_MIN, 1, -1, -1, 0);     // most negative on both parts
        plan(FN_LOAD, S32_MAX, 0, 1, S32_MAX, 0, 0);       // zero denominator is kept
        plan(FN_ADD, 1, 1, 0, 0, 0, 0);                    // zero denominator propagates
        plan(FN_LOAD, -6, 4, 1, -3, 2, 0);                 // negative part reduced too
        plan(FN_ADD, 1, 2, 0, 0, 0, 0);
        plan(FN_SUB, 3, -4, 0, 0, 0, 0);                   // signs are never normalized
        plan(FN_MUL, -5, 7, 0, 0, 0, 0);
        plan(FN_DIV, 2, 3, 0, 0, 0, 0);
        plan(FN_RSV6, S32_MAX, S32_MIN, 0, 0, 0, 0);       // spare code shows the accumulator
        plan(FN_DIV, 0, 1, 0, 0, 0, 0);                    // divide by zero operand
        plan(FN_LOAD, 65536, 1, 1, 65536, 1, 0);
        plan(FN_MUL, 65536, 1, 1, 0, 1, 1);                // product wraps to zero
        plan(FN_LOAD, S32_MIN, 1, 1, S32_MIN, 1, 0);
        plan(FN_MUL, -1, 1, 1, S32_MIN, 1, 1);             // negating the most negative word
        plan(FN_LOAD, S32_MAX, 1, 1, S32_MAX, 1, 0);
        plan(FN_ADD, 1, 1, 1, S32_MIN, 1, 1);              // sum wraps
        plan(FN_LOAD, S32_MIN, 1, 1, S32_MIN, 1, 0);
        plan(FN_SUB, 1, 1, 1, S32_MAX, 1, 1);              // difference wraps
        plan(FN_LOAD, S32_MAX, S32_MAX, 1, 1, 1, 0);
        plan(FN_LOAD, S32_MIN, S32_MAX, 1, S32_MIN, S32_MAX, 0); // coprime extremes
        plan(FN_DIV, -1, S32_MIN, 0, 0, 0, 0);
        plan(FN_RSV7, -1, -1, 0, 0, 0, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i].item, directed_rows[i].typed,
                       directed_rows[i].want, pick_gap());

        // Let the block go fully idle once before the random part.
        wait_for_drain();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2)
                wait_for_drain();
            item.func        = pick_func();
            item.operand_num = pick_part();
            item.operand_den = pick_part();
            offer_item(item, 1'b0, '0, pick_gap());
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random ready, one long hold-off once results are flowing
    // ------------------------------------------------------------------
    initial begin
        int unsigned pick;
        wait (i_rst_n === 1'b1);
        forever begin
            pick = $urandom_range(0, 99);
            if (!holdoff_done && results_seen >= 60) begin
                // Hold off while the sender keeps offering, so the input side backs up.
                holdoff_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end else if (pick < 5) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(100, 300)) @(posedge i_clk);
            end else if (pick < 55) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else if (pick < 92) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each taken item with the oldest owed fraction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            results_seen++;
            if (awaited_fractions.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result item %0d/%0d ovf %0b", $time,
                         o_out_data.result_num, o_out_data.result_den, o_out_data.overflow);
            end else begin
                want = awaited_fractions.pop_front();
                if (o_out_data.result_num !== want.result_num) begin
                    mismatch_count++;
                    $display("%0t: result_num expected %0d, actual %0d", $time,
                             want.result_num, o_out_data.result_num);
                end
                if (o_out_data.result_den !== want.result_den) begin
                    mismatch_count++;
                    $display("%0t: result_den expected %0d, actual %0d", $time,
                             want.result_den, o_out_data.result_den);
                end
                if (o_out_data.overflow !== want.overflow) begin
                    mismatch_count++;
                    $display("%0t: overflow expected %0b, actual %0b", $time,
                             want.overflow, o_out_data.overflow);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no item moves on either side for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready === 1'b1)
            || (o_out_valid === 1'b1 && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d results still owed", $time,
                     quiet_cycles, awaited_fractions.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
